FILE: rtl/core/pwbr_pkg.sv
// shared types and constants for the pulse width byte receiver
package pwbr_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 8;
    localparam int POS_W   = 3;
    localparam int LEFT_W  = 6;

    localparam logic [BYTE_W-1:0]  RESET_THRESHOLD = 8'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;
    localparam logic [POS_W-1:0]   LAST_BIT_POS    = 3'd7;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] byte_value;
        logic              is_length_byte;
        logic              last_in_frame;
    } t_pwbr_result;

endpackage

FILE: rtl/core/pulse_width_byte_receiver_unit.sv
// top level of the pulse width byte receiver
//
// channel   dir  tdata              tuser            tlast
// s_axis    in   [0] line_level     -                -
// m_axis    out  [7:0] byte_value   [0] is_length    last_in_frame
// cfg       in   [7:0] one_threshold (write enable, no read-back)
//
// one sample accepted every clock while the result register is not stalled
// stages: input register, then decode into the result register
// reset clears all decode state and sets the threshold to 4
// a stalled result register holds the decode stage; a full input register holds too
module pulse_width_byte_receiver_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [0] line_level, rest zero
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pwbr_pkg::BYTE_W-1:0]  m_axis_tdata,   // [7:0] byte_value
    output logic                         m_axis_tuser,   // [0] is_length_byte
    output logic                         m_axis_tlast,
    input  logic                         i_cfg_wr_en,
    input  logic [pwbr_pkg::BYTE_W-1:0]  i_cfg_wr_data
);
    import pwbr_pkg::*;

    logic [BYTE_W-1:0] r_thr;
    logic              r_in_valid;
    logic              r_in_level;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_len;
    logic              r_out_last;
    logic              advance;
    t_pwbr_result      result;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= RESET_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_level <= s_axis_tdata[0];
        end
    end

    pwbr_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_level     (r_in_level),
        .i_threshold (r_thr),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_byte <= result.byte_value;
            r_out_len  <= result.is_length_byte;
            r_out_last <= result.last_in_frame;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_len;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast == (m_axis_tdata == '0))
        else $error("length header last flag does not match its length");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_level))
        else $error("stalled sample lost from input register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !advance)
        else $error("decode advanced over an untaken result");

    a_cfg_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> r_thr == $past(i_cfg_wr_data))
        else $error("threshold write not applied");
`endif

endmodule

FILE: rtl/core/pwbr_decode.sv
// pulse measurement, bit packing and frame tracking for one line sample
module pwbr_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_level,
    input  logic [pwbr_pkg::BYTE_W-1:0]  i_threshold,
    output pwbr_pkg::t_pwbr_result       o_result
);
    import pwbr_pkg::*;

    logic               r_in_pulse,    n_in_pulse;
    logic [COUNT_W-1:0] r_pulse_count, n_pulse_count;
    logic [POS_W-1:0]   r_bit_pos,     n_bit_pos;
    logic [BYTE_W-1:0]  r_shift_byte,  n_shift_byte;
    logic               r_in_payload,  n_in_payload;
    logic [LEFT_W-1:0]  r_bytes_left,  n_bytes_left;

    logic               bit_val;
    logic [BYTE_W-1:0]  packed_byte;
    logic [BYTE_W:0]    len_round;
    logic [LEFT_W-1:0]  len_bytes;
    logic [LEFT_W-1:0]  left_dec;

    always_comb begin
        bit_val     = (r_pulse_count > i_threshold);
        packed_byte = r_shift_byte | (BYTE_W'(bit_val) << r_bit_pos);
        len_round   = {1'b0, packed_byte} + (BYTE_W+1)'(7);
        len_bytes   = LEFT_W'(len_round >> 3);
        left_dec    = (r_bytes_left != '0) ? r_bytes_left - LEFT_W'(1) : '0;

        n_in_pulse    = r_in_pulse;
        n_pulse_count = r_pulse_count;
        n_bit_pos     = r_bit_pos;
        n_shift_byte  = r_shift_byte;
        n_in_payload  = r_in_payload;
        n_bytes_left  = r_bytes_left;

        o_result                = '0;
        o_result.byte_value     = packed_byte;

        if (i_step) begin
            if (i_level) begin
                if (!r_in_pulse) begin
                    n_in_pulse    = 1'b1;
                    n_pulse_count = COUNT_W'(1);
                end else if (r_pulse_count != COUNT_MAX) begin
                    n_pulse_count = r_pulse_count + COUNT_W'(1);
                end
            end else if (r_in_pulse) begin
                // falling edge, one bit decoded
                n_in_pulse    = 1'b0;
                n_pulse_count = '0;
                if (r_bit_pos != LAST_BIT_POS) begin
                    n_bit_pos    = r_bit_pos + POS_W'(1);
                    n_shift_byte = packed_byte;
                end else begin
                    n_bit_pos      = '0;
                    n_shift_byte   = '0;
                    o_result.valid = 1'b1;
                    if (!r_in_payload) begin
                        o_result.is_length_byte = 1'b1;
                        if (len_bytes == '0) begin
                            o_result.last_in_frame = 1'b1;
                        end else begin
                            n_in_payload = 1'b1;
                            n_bytes_left = len_bytes;
                        end
                    end else begin
                        n_bytes_left = left_dec;
                        if (left_dec == '0) begin
                            o_result.last_in_frame = 1'b1;
                            n_in_payload           = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pulse    <= 1'b0;
            r_pulse_count <= '0;
            r_bit_pos     <= '0;
            r_shift_byte  <= '0;
            r_in_payload  <= 1'b0;
            r_bytes_left  <= '0;
        end else begin
            r_in_pulse    <= n_in_pulse;
            r_pulse_count <= n_pulse_count;
            r_bit_pos     <= n_bit_pos;
            r_shift_byte  <= n_shift_byte;
            r_in_payload  <= n_in_payload;
            r_bytes_left  <= n_bytes_left;
        end
    end

`ifndef NO_ASSERTIONS
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload == (r_bytes_left != '0))
        else $error("payload flag and byte count disagree");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pulse_count) && $stable(r_bit_pos) && $stable(r_shift_byte))
        else $error("decoder state moved without a step");

    a_count_zero_outside_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_pulse |-> r_pulse_count == '0)
        else $error("pulse count nonzero outside a pulse");
`endif

endmodule
